// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QOA_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qoa assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qoa assertion failed");

`endif

// ----- rtl/qoa_pkg.sv -----
// Package with shared constants, types and the dequantization table of the decoder.
`default_nettype none
package qoa_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SLICE_SAMPLES = 20;
    localparam int LMS_TAPS = 4;

    localparam logic [31:0] MAGIC = 32'h716f6166;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_MAGIC = 3'd1;
    localparam logic [2:0] STAT_BAD_CHAN  = 3'd2;
    localparam logic [2:0] STAT_MISMATCH  = 3'd3;
    localparam logic [2:0] STAT_IGNORED   = 3'd4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         channel;
        logic [15:0]        frame_position;
        logic               sample_valid;
        logic               last;
        logic [2:0]         status;
    } t_result;

    typedef struct packed {
        logic load;
        logic start;
        logic commit;
    } t_lms_ctrl;

    localparam logic [15:0] DQ_MAG [64] = '{
        16'd1,    16'd3,    16'd5,    16'd7,
        16'd5,    16'd18,   16'd32,   16'd49,
        16'd16,   16'd53,   16'd95,   16'd147,
        16'd34,   16'd113,  16'd203,  16'd315,
        16'd63,   16'd210,  16'd378,  16'd588,
        16'd104,  16'd345,  16'd621,  16'd966,
        16'd158,  16'd528,  16'd950,  16'd1477,
        16'd228,  16'd760,  16'd1368, 16'd2128,
        16'd316,  16'd1053, 16'd1895, 16'd2947,
        16'd422,  16'd1405, 16'd2529, 16'd3934,
        16'd548,  16'd1828, 16'd3290, 16'd5117,
        16'd696,  16'd2320, 16'd4176, 16'd6496,
        16'd868,  16'd2893, 16'd5207, 16'd8099,
        16'd1064, 16'd3548, 16'd6386, 16'd9933,
        16'd1286, 16'd4288, 16'd7718, 16'd12005,
        16'd1536, 16'd5120, 16'd9216, 16'd14336
    };

    function automatic logic signed [15:0] dq_value(input logic [3:0] sf,
                                                     input logic [2:0] code);
        logic signed [15:0] mag;
        mag = signed'(DQ_MAG[{sf, code[2:1]}]);
        return code[0] ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qoa_lms_unit.sv -----
// Shared LMS unit: one multiplier walks the four taps, then the predictor is updated.
`default_nettype none
module qoa_lms_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire qoa_pkg::t_lms_ctrl i_ctrl,
    input  wire logic [63:0]        i_hist,
    input  wire logic [127:0]       i_wts,
    input  wire logic signed [15:0] i_dq,
    output logic                    o_done,
    output logic signed [15:0]      o_rec,
    output logic [63:0]             o_hist,
    output logic [127:0]            o_wts
);

    logic signed [15:0] r_h [qoa_pkg::LMS_TAPS];
    logic signed [31:0] r_w [qoa_pkg::LMS_TAPS];
    logic [2:0]         r_tap;
    logic               r_run;
    logic               r_done;
    logic signed [47:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [37:0] pre;
    logic signed [15:0] delta;
    logic signed [31:0] delta32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_tap  <= 3'd0;
        end else if (i_ctrl.start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_tap  <= 3'd0;
        end else if (r_run) begin
            r_tap <= r_tap + 3'd1;
            if (r_tap == 3'(qoa_pkg::LMS_TAPS)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_acc <= '0;
        end else if (r_run) begin
            if (r_tap != 3'd0) begin
                r_acc <= r_acc + 50'(r_prod);
            end
            if (r_tap < 3'(qoa_pkg::LMS_TAPS)) begin
                r_prod <= r_w[r_tap[1:0]] * r_h[r_tap[1:0]];
            end
        end
    end

    always_comb begin
        pre = 38'($signed(r_acc[49:13])) + 38'(i_dq);
        if (pre > 38'sd32767) begin
            o_rec = 16'sh7fff;
        end else if (pre < -38'sd32768) begin
            o_rec = 16'sh8000;
        end else begin
            o_rec = pre[15:0];
        end
        delta   = i_dq >>> 4;
        delta32 = 32'(delta);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int i = 0; i < qoa_pkg::LMS_TAPS; i++) begin
                r_h[i] <= i_hist[63-16*i -: 16];
                r_w[i] <= i_wts[127-32*i -: 32];
            end
        end else if (i_ctrl.commit) begin
            for (int i = 0; i < qoa_pkg::LMS_TAPS; i++) begin
                r_w[i] <= r_w[i] + (r_h[i][15] ? -delta32 : delta32);
            end
            for (int i = 0; i < qoa_pkg::LMS_TAPS - 1; i++) begin
                r_h[i] <= r_h[i+1];
            end
            r_h[qoa_pkg::LMS_TAPS-1] <= o_rec;
        end
    end

    always_comb begin
        for (int i = 0; i < qoa_pkg::LMS_TAPS; i++) begin
            o_hist[63-16*i -: 16] = r_h[i];
            o_wts[127-32*i -: 32] = r_w[i];
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- rtl/qoa_out_reg.sv -----
// Output register that holds one result beat until the downstream side takes it.
`default_nettype none
module qoa_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire qoa_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // sample, channel, frame_position, zero fill
    output logic                  m_axis_tlast,
    output logic [3:0]            m_axis_tuser   // sample_valid, status
);

    logic             r_valid;
    qoa_pkg::t_result r_res;

    assign o_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_res.frame_position, r_res.channel, r_res.sample};
    assign m_axis_tlast  = r_res.last;
    assign m_axis_tuser  = {r_res.status, r_res.sample_valid};

endmodule
`default_nettype wire

// ----- rtl/qoa_audio_decoder_unit.sv -----
// Top level of the QOA stream decoder: word parser, sequencer and channel state memories.
// The decoder takes one 64-bit big-endian stream word per beat. A file header, frame header
// or LMS word is answered with one status beat, plus any wait for the output register. A
// slice word loads the channel state into the shared unit; then, for each sample of the
// slice, the sequencer starts the unit, waits while the single 32x16 multiply-accumulate
// unit walks the four LMS taps one per cycle, adds the last product and reports done, and
// forms, emits and commits the sample, with any wait for the output register. Write-back
// ends a full slice of 20 samples; s_axis_tready stays low while a word is being worked on.
// Per-channel LMS history and weights live in two small memories loaded by each frame's
// LMS words. Errors are sticky until a word with stream_start set in tuser.
`default_nettype none
module qoa_audio_decoder_unit #(
    parameter int MAX_CHANNELS = qoa_pkg::MAX_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // word
    input  wire logic [0:0]  s_axis_tuser,   // stream_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // sample, channel, frame_position, zero fill
    output logic             m_axis_tlast,
    output logic [3:0]       m_axis_tuser    // sample_valid, status
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [2:0] PH_FILE         = 3'd0;
    localparam logic [2:0] PH_FRAME        = 3'd1;
    localparam logic [2:0] PH_LMS          = 3'd2;
    localparam logic [2:0] PH_SLICE        = 3'd3;
    localparam logic [2:0] PH_DONE         = 3'd4;
    localparam logic [2:0] PH_ERR_MAGIC    = 3'd5;
    localparam logic [2:0] PH_ERR_CHAN     = 3'd6;
    localparam logic [2:0] PH_ERR_MISMATCH = 3'd7;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LD   = 3'd1;
    localparam logic [2:0] ST_GO   = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;
    localparam logic [2:0] ST_RES  = 3'd6;

    logic [2:0]  r_st, n_st;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_chans, n_chans;
    logic [23:0] r_rate, n_rate;
    logic [31:0] r_total, n_total;
    logic [31:0] r_decoded, n_decoded;
    logic [15:0] r_fsamp, n_fsamp;
    logic [15:0] r_sstart, n_sstart;
    logic [8:0]  r_wcnt, n_wcnt;
    logic [2:0]  r_status, n_status;
    logic [59:0] r_word, n_word;
    logic [3:0]  r_sf, n_sf;
    logic [15:0] r_si, n_si;
    logic [15:0] r_end, n_end;
    logic        r_any, n_any;

    logic [63:0]  hist_mem [MAX_CHANNELS];
    logic [127:0] wt_mem [MAX_CHANNELS];
    logic [63:0]  r_hrd;
    logic [127:0] r_wrd;
    logic         hist_we, wt_we;
    logic [AW-1:0] wr_idx;
    logic [63:0]  hist_d;
    logic [127:0] wt_d;

    logic               accept;
    logic               out_ready;
    logic               push;
    qoa_pkg::t_result   res;
    qoa_pkg::t_lms_ctrl ctrl;
    logic               lms_done;
    logic signed [15:0] rec;
    logic signed [15:0] dq;
    logic [63:0]        lms_hist;
    logic [127:0]       lms_wts;

    logic [32:0] fe_sum;
    logic [31:0] fe_decoded;
    logic [32:0] pos_now, pos_next;
    logic        emit, emit_next, fin_last;
    logic [8:0]  wcnt_inc;
    logic [16:0] ss_next;
    logic [16:0] slice_stop;
    logic [7:0]  ch_in;
    logic [23:0] rate_in;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign dq            = qoa_pkg::dq_value(r_sf, r_word[59:57]);

    always_comb begin
        fe_sum     = {1'b0, r_decoded} + 33'(r_fsamp);
        fe_decoded = fe_sum[32] ? 32'hffff_ffff : fe_sum[31:0];
        pos_now    = {1'b0, r_decoded} + 33'(r_si);
        pos_next   = pos_now + 33'd1;
        emit       = pos_now < {1'b0, r_total};
        emit_next  = pos_next < {1'b0, r_total};
        fin_last   = (r_si + 16'd1) == r_end;
        wcnt_inc   = r_wcnt + 9'd1;
        ss_next    = 17'(r_sstart) + 17'(qoa_pkg::SLICE_SAMPLES);
        slice_stop = (ss_next > 17'(r_fsamp)) ? 17'(r_fsamp) : ss_next;
        ch_in      = s_axis_tdata[63:56];
        rate_in    = s_axis_tdata[55:32];
    end

    always_comb begin
        n_st      = r_st;
        n_phase   = r_phase;
        n_chans   = r_chans;
        n_rate    = r_rate;
        n_total   = r_total;
        n_decoded = r_decoded;
        n_fsamp   = r_fsamp;
        n_sstart  = r_sstart;
        n_wcnt    = r_wcnt;
        n_status  = r_status;
        n_word    = r_word;
        n_sf      = r_sf;
        n_si      = r_si;
        n_end     = r_end;
        n_any     = r_any;
        hist_we   = 1'b0;
        wt_we     = 1'b0;
        wr_idx    = r_wcnt[AW-1:0];
        hist_d    = lms_hist;
        wt_d      = lms_wts;
        ctrl      = '0;
        push      = 1'b0;
        res       = '0;
        res.last  = 1'b1;
        res.status = r_status;

        unique case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    n_status = qoa_pkg::STAT_OK;
                    n_st     = ST_RES;
                    if (s_axis_tuser[0]) begin
                        n_chans   = '0;
                        n_rate    = '0;
                        n_total   = '0;
                        n_decoded = '0;
                        n_fsamp   = '0;
                        n_sstart  = '0;
                        n_wcnt    = '0;
                        if (s_axis_tdata[63:32] != qoa_pkg::MAGIC) begin
                            n_phase  = PH_ERR_MAGIC;
                            n_status = qoa_pkg::STAT_BAD_MAGIC;
                        end else begin
                            n_total = s_axis_tdata[31:0];
                            n_phase = PH_FRAME;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_FILE, PH_DONE: begin
                                n_status = qoa_pkg::STAT_IGNORED;
                            end
                            PH_ERR_MAGIC: begin
                                n_status = qoa_pkg::STAT_BAD_MAGIC;
                            end
                            PH_ERR_CHAN: begin
                                n_status = qoa_pkg::STAT_BAD_CHAN;
                            end
                            PH_ERR_MISMATCH: begin
                                n_status = qoa_pkg::STAT_MISMATCH;
                            end
                            PH_FRAME: begin
                                if (r_decoded >= r_total) begin
                                    n_phase  = PH_DONE;
                                    n_status = qoa_pkg::STAT_IGNORED;
                                end else if (r_chans == 8'd0 &&
                                             (ch_in == 8'd0 || ch_in > 8'(MAX_CHANNELS))) begin
                                    n_phase  = PH_ERR_CHAN;
                                    n_status = qoa_pkg::STAT_BAD_CHAN;
                                end else if (r_chans != 8'd0 &&
                                             (ch_in != r_chans || rate_in != r_rate)) begin
                                    n_phase  = PH_ERR_MISMATCH;
                                    n_status = qoa_pkg::STAT_MISMATCH;
                                end else begin
                                    n_chans  = ch_in;
                                    n_rate   = rate_in;
                                    n_fsamp  = s_axis_tdata[31:16];
                                    n_sstart = '0;
                                    n_wcnt   = '0;
                                    n_phase  = PH_LMS;
                                end
                            end
                            PH_LMS: begin
                                wr_idx = r_wcnt[AW:1];
                                hist_d = s_axis_tdata;
                                for (int i = 0; i < qoa_pkg::LMS_TAPS; i++) begin
                                    wt_d[127-32*i -: 32] = 32'($signed(s_axis_tdata[63-16*i -: 16]));
                                end
                                hist_we = !r_wcnt[0];
                                wt_we   = r_wcnt[0];
                                if (wcnt_inc >= {r_chans, 1'b0}) begin
                                    n_wcnt = '0;
                                    if (r_fsamp == 16'd0) begin
                                        n_decoded = fe_decoded;
                                        n_phase   = PH_FRAME;
                                    end else begin
                                        n_phase = PH_SLICE;
                                    end
                                end else begin
                                    n_wcnt = wcnt_inc;
                                end
                            end
                            PH_SLICE: begin
                                n_sf   = s_axis_tdata[63:60];
                                n_word = s_axis_tdata[59:0];
                                n_si   = r_sstart;
                                n_end  = slice_stop[15:0];
                                n_any  = 1'b0;
                                n_st   = ST_LD;
                            end
                            default: begin
                                n_status = qoa_pkg::STAT_IGNORED;
                            end
                        endcase
                    end
                end
            end
            ST_LD: begin
                ctrl.load = 1'b1;
                n_st      = ST_GO;
            end
            ST_GO: begin
                ctrl.start = 1'b1;
                n_st       = ST_WAIT;
            end
            ST_WAIT: begin
                if (lms_done) begin
                    n_st = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!emit || out_ready) begin
                    ctrl.commit        = 1'b1;
                    push               = emit;
                    res.sample         = rec;
                    res.channel        = r_wcnt[2:0];
                    res.frame_position = r_si;
                    res.sample_valid   = 1'b1;
                    res.last           = fin_last || !emit_next;
                    res.status         = qoa_pkg::STAT_OK;
                    if (emit) begin
                        n_any = 1'b1;
                    end
                    n_si   = r_si + 16'd1;
                    n_word = {r_word[56:0], 3'd0};
                    n_st   = fin_last ? ST_WB : ST_GO;
                end
            end
            ST_WB: begin
                if (r_any || out_ready) begin
                    push       = !r_any;
                    res.status = qoa_pkg::STAT_OK;
                    hist_we    = 1'b1;
                    wt_we      = 1'b1;
                    if (wcnt_inc >= {1'b0, r_chans}) begin
                        n_wcnt = '0;
                        if (ss_next >= 17'(r_fsamp)) begin
                            n_sstart  = '0;
                            n_decoded = fe_decoded;
                            n_phase   = PH_FRAME;
                        end else begin
                            n_sstart = ss_next[15:0];
                        end
                    end else begin
                        n_wcnt = wcnt_inc;
                    end
                    n_st = ST_IDLE;
                end
            end
            ST_RES: begin
                if (out_ready) begin
                    push = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_phase   <= PH_FILE;
            r_chans   <= '0;
            r_rate    <= '0;
            r_total   <= '0;
            r_decoded <= '0;
            r_fsamp   <= '0;
            r_sstart  <= '0;
            r_wcnt    <= '0;
            r_status  <= qoa_pkg::STAT_OK;
            r_any     <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_phase   <= n_phase;
            r_chans   <= n_chans;
            r_rate    <= n_rate;
            r_total   <= n_total;
            r_decoded <= n_decoded;
            r_fsamp   <= n_fsamp;
            r_sstart  <= n_sstart;
            r_wcnt    <= n_wcnt;
            r_status  <= n_status;
            r_any     <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_sf   <= n_sf;
        r_si   <= n_si;
        r_end  <= n_end;
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[wr_idx] <= hist_d;
        end
        if (wt_we) begin
            wt_mem[wr_idx] <= wt_d;
        end
        r_hrd <= hist_mem[r_wcnt[AW-1:0]];
        r_wrd <= wt_mem[r_wcnt[AW-1:0]];
    end

    qoa_lms_unit u_lms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_hist  (r_hrd),
        .i_wts   (r_wrd),
        .i_dq    (dq),
        .o_done  (lms_done),
        .o_rec   (rec),
        .o_hist  (lms_hist),
        .o_wts   (lms_wts)
    );

    qoa_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_res         (res),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ----- rtl/qoa_checker.sv -----
// Port-level checker for the decoder and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module qoa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [63:0] s_axis_tdata,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic [3:0]  m_axis_tuser
);

    logic s_beat;
    logic m_hold;
    assign s_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                    && (s_axis_tuser == s_axis_tuser);
    assign m_hold = m_axis_tvalid && !m_axis_tready;

    // A stalled result beat stays on the bus unchanged.
    `QOA_ASSERT_NEXT(a_out_hold, m_hold, m_axis_tvalid && $stable(m_axis_tdata))
    // A beat without a sample is always the last one of its input word.
    `QOA_ASSERT(a_empty_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
    // A beat without a sample carries zero sample, channel and position.
    `QOA_ASSERT(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 40'd0)
    // Samples only travel with an ok status.
    `QOA_ASSERT(a_sample_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:1] == 3'd0)
    // Each accepted word closes the input side in the following cycle.
    `QOA_ASSERT_NEXT(a_busy_after, s_beat, !s_axis_tready)

endmodule

bind qoa_audio_decoder_unit qoa_checker u_chk (.*);
`default_nettype wire
